@@ hw/rtl/opr_pkg.sv @@
`timescale 1ns / 1ps

package opr_pkg;

  localparam int NODES      = 64;
  localparam int MAX_DEGREE = 8;
  localparam int PLAYERS    = 8;

  // Fixed field widths of the stream words.
  localparam int OPC_W = 2;
  localparam int FNODE_W = 6;
  localparam int SLOT_W = 3;
  localparam int NBR_W = 6;
  localparam int FDEG_W = 4;
  localparam int OWN_W = 3;
  localparam int PLY_W = 3;

  // Derived storage widths.
  localparam int NODE_W  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int DEG_W   = $clog2(MAX_DEGREE + 1);
  localparam int DEPTH_W = $clog2(NODES + 1);
  localparam int ADJ_N   = NODES * MAX_DEGREE;
  localparam int ADJ_AW  = $clog2(ADJ_N);
  localparam int STK_W   = NODE_W + DEG_W;

  // Player ids are compared as given; this width must cover every player.
  localparam int PLY_NEED_W = $clog2(PLAYERS);

  typedef enum logic [OPC_W-1:0] {
    OP_WR_SLOT = 2'd0,
    OP_SET_DEG = 2'd1,
    OP_SET_OWN = 2'd2,
    OP_QUERY   = 2'd3
  } opcode_t;

  typedef struct packed {
    logic wr_adj;
    logic wr_deg;
    logic wr_own;
    logic q_init;
    logic rd_adj;
    logic chk_adj;
    logic push;
    logic mark;
    logic pop;
    logic restore;
    logic set_res;
    logic res_val;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic in_bad;
    logic cur_done;
    logic last_frame;
    logic skip_next;
    logic own_match;
    logic goal_hit;
    logic stack_full;
  } sts_t;

endpackage

@@ hw/rtl/owned_path_reachability_unit.sv @@
`timescale 1ns / 1ps
// Table writes (slot, degree, owner) produce no output word.
// A query runs a depth-first walk with one adjacency RAM read per slot: each slot
// is read, a neighbor that passes the range and visited checks also gets an owner
// check, a backtrack pops and restores a stack frame, and a last step posts the answer.
// Reset (rst_n low, synchronous) empties the degree and owner tables and the output.

module owned_path_reachability_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // node[5:0], slot[8:6], neighbor[14:9], degree[18:15], owner[21:19],
  // target[27:22], player[30:28], zero[31]
  input  logic [31:0] in_tdata,
  // opcode[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // reachable[0], zero[7:1]
  output logic [7:0]  out_tdata
);

  opr_pkg::cmd_t cmd;
  opr_pkg::sts_t sts;
  logic          reachable;

  opr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_opcode  (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  opr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_node       (in_tdata[5:0]),
    .in_slot       (in_tdata[8:6]),
    .in_neighbor   (in_tdata[14:9]),
    .in_degree     (in_tdata[18:15]),
    .in_owner      (in_tdata[21:19]),
    .in_target     (in_tdata[27:22]),
    .in_player     (in_tdata[30:28]),
    .cmd           (cmd),
    .sts           (sts),
    .out_reachable (reachable)
  );

  assign out_tdata = {7'b0, reachable};

endmodule

@@ hw/rtl/opr_ram.sv @@
`timescale 1ns / 1ps

module opr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/opr_ctrl.sv @@
`timescale 1ns / 1ps

module opr_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [opr_pkg::OPC_W-1:0]     in_opcode,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  opr_pkg::sts_t                 sts,
  output opr_pkg::cmd_t                 cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SLOT = 6'b000010,
    S_ADJ  = 6'b000100,
    S_OWN  = 6'b001000,
    S_POP  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (opr_pkg::opcode_t'(in_opcode))
            opr_pkg::OP_WR_SLOT: cmd.wr_adj = 1'b1;
            opr_pkg::OP_SET_DEG: cmd.wr_deg = 1'b1;
            opr_pkg::OP_SET_OWN: cmd.wr_own = 1'b1;
            opr_pkg::OP_QUERY: begin
              if (sts.in_bad) begin
                cmd.set_res = 1'b1;
                state_nxt = S_DONE;
              end else begin
                cmd.q_init = 1'b1;
                state_nxt = S_SLOT;
              end
            end
            default: ;
          endcase
        end
      end
      S_SLOT: begin
        if (sts.cur_done) begin
          if (sts.last_frame) begin
            cmd.set_res = 1'b1;
            state_nxt = S_DONE;
          end else begin
            cmd.pop = 1'b1;
            state_nxt = S_POP;
          end
        end else begin
          cmd.rd_adj = 1'b1;
          state_nxt = S_ADJ;
        end
      end
      S_ADJ: begin
        cmd.chk_adj = 1'b1;
        state_nxt = sts.skip_next ? S_SLOT : S_OWN;
      end
      S_OWN: begin
        state_nxt = S_SLOT;
        if (sts.own_match) begin
          if (sts.goal_hit) begin
            cmd.set_res = 1'b1;
            cmd.res_val = 1'b1;
            state_nxt = S_DONE;
          end else if (!sts.stack_full) begin
            cmd.push = 1'b1;
          end else begin
            cmd.mark = 1'b1;
          end
        end
      end
      S_POP: begin
        cmd.restore = 1'b1;
        state_nxt = S_SLOT;
      end
      S_DONE: begin
        // Hold the answer until the output register is free.
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hw/rtl/opr_dp.sv @@
`timescale 1ns / 1ps

module opr_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [opr_pkg::FNODE_W-1:0]   in_node,
  input  logic [opr_pkg::SLOT_W-1:0]    in_slot,
  input  logic [opr_pkg::NBR_W-1:0]     in_neighbor,
  input  logic [opr_pkg::FDEG_W-1:0]    in_degree,
  input  logic [opr_pkg::OWN_W-1:0]     in_owner,
  input  logic [opr_pkg::FNODE_W-1:0]   in_target,
  input  logic [opr_pkg::PLY_W-1:0]     in_player,
  input  opr_pkg::cmd_t                 cmd,
  output opr_pkg::sts_t                 sts,
  output logic                          out_reachable
);

  localparam int NODE_W  = opr_pkg::NODE_W;
  localparam int DEG_W   = opr_pkg::DEG_W;
  localparam int DEPTH_W = opr_pkg::DEPTH_W;
  localparam int ADJ_AW  = opr_pkg::ADJ_AW;
  localparam int STK_W   = opr_pkg::STK_W;

  // Walk registers: the top stack frame lives here, lower frames in the stack RAM.
  logic [NODE_W-1:0]              top_r, top_nxt;
  logic [DEG_W-1:0]               cur_r, cur_nxt;
  logic [DEPTH_W-1:0]             depth_r, depth_nxt;
  logic [opr_pkg::NBR_W-1:0]      next_r, next_nxt;
  logic [opr_pkg::FNODE_W-1:0]    goal_r, goal_nxt;
  logic [opr_pkg::PLY_W-1:0]      player_r, player_nxt;
  logic [opr_pkg::NODES-1:0]      visited_r, visited_nxt;
  logic [opr_pkg::NODES-1:0]      deg_vld_r, deg_vld_nxt;
  logic [opr_pkg::NODES-1:0]      own_vld_r, own_vld_nxt;
  logic                           res_r, res_nxt;
  logic                           out_reach_r, out_reach_nxt;

  logic [ADJ_AW-1:0]              adj_waddr, adj_raddr;
  logic [opr_pkg::NBR_W-1:0]      adj_rdata;
  logic [DEG_W-1:0]               deg_wdata, deg_rdata, deg_eff;
  logic [opr_pkg::OWN_W-1:0]      own_rdata, own_eff;
  logic [STK_W-1:0]               stk_wdata, stk_rdata;
  logic [NODE_W-1:0]              stk_waddr, stk_raddr;
  logic [NODE_W-1:0]              in_node_idx, next_idx, adj_idx;
  logic                           node_ok, slot_ok;

  assign in_node_idx = NODE_W'(in_node);
  assign next_idx    = NODE_W'(next_r);
  assign adj_idx     = NODE_W'(adj_rdata);
  assign node_ok     = 32'(in_node) < opr_pkg::NODES;
  assign slot_ok     = 32'(in_slot) < opr_pkg::MAX_DEGREE;

  assign deg_wdata = (32'(in_degree) > opr_pkg::MAX_DEGREE) ?
                     DEG_W'(opr_pkg::MAX_DEGREE) : DEG_W'(in_degree);

  assign adj_waddr = ADJ_AW'(in_node) * ADJ_AW'(opr_pkg::MAX_DEGREE) + ADJ_AW'(in_slot);
  assign adj_raddr = ADJ_AW'(top_r) * ADJ_AW'(opr_pkg::MAX_DEGREE) + ADJ_AW'(cur_r);

  assign stk_waddr = NODE_W'(depth_r - DEPTH_W'(1));
  assign stk_raddr = NODE_W'(depth_r - DEPTH_W'(2));
  assign stk_wdata = {top_r, cur_r};

  // Entries that were never written read as zero.
  assign deg_eff = deg_vld_r[top_r] ? deg_rdata : '0;
  assign own_eff = own_vld_r[next_idx] ? own_rdata : '0;

  // The degree RAM follows the next top node, so its data matches top_r.
  opr_ram #(.WIDTH(DEG_W), .DEPTH(opr_pkg::NODES)) u_deg_ram (
    .clk   (clk),
    .we    (cmd.wr_deg && node_ok),
    .waddr (in_node_idx),
    .wdata (deg_wdata),
    .raddr (top_nxt),
    .rdata (deg_rdata)
  );

  // The owner RAM is addressed by the neighbor just read; its data is ready in the next cycle.
  opr_ram #(.WIDTH(opr_pkg::OWN_W), .DEPTH(opr_pkg::NODES)) u_own_ram (
    .clk   (clk),
    .we    (cmd.wr_own && node_ok),
    .waddr (in_node_idx),
    .wdata (in_owner),
    .raddr (adj_idx),
    .rdata (own_rdata)
  );

  opr_ram #(.WIDTH(opr_pkg::NBR_W), .DEPTH(opr_pkg::ADJ_N)) u_adj_ram (
    .clk   (clk),
    .we    (cmd.wr_adj && node_ok && slot_ok),
    .waddr (adj_waddr),
    .wdata (in_neighbor),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  opr_ram #(.WIDTH(STK_W), .DEPTH(opr_pkg::NODES)) u_stk_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  always_comb begin
    top_nxt = top_r;
    cur_nxt = cur_r;
    depth_nxt = depth_r;
    next_nxt = next_r;
    goal_nxt = goal_r;
    player_nxt = player_r;
    visited_nxt = visited_r;
    deg_vld_nxt = deg_vld_r;
    own_vld_nxt = own_vld_r;
    res_nxt = res_r;
    out_reach_nxt = out_reach_r;

    if (cmd.wr_deg && node_ok) begin
      deg_vld_nxt[in_node_idx] = 1'b1;
    end
    if (cmd.wr_own && node_ok) begin
      own_vld_nxt[in_node_idx] = 1'b1;
    end
    if (cmd.q_init) begin
      top_nxt = in_node_idx;
      cur_nxt = '0;
      depth_nxt = DEPTH_W'(1);
      goal_nxt = in_target;
      player_nxt = in_player;
      visited_nxt = '0;
      visited_nxt[in_node_idx] = 1'b1;
    end
    if (cmd.rd_adj) begin
      cur_nxt = cur_r + DEG_W'(1);
    end
    if (cmd.chk_adj) begin
      next_nxt = adj_rdata;
    end
    if (cmd.push || cmd.mark) begin
      visited_nxt[next_idx] = 1'b1;
    end
    if (cmd.push) begin
      top_nxt = next_idx;
      cur_nxt = '0;
      depth_nxt = depth_r + DEPTH_W'(1);
    end
    if (cmd.pop) begin
      depth_nxt = depth_r - DEPTH_W'(1);
    end
    if (cmd.restore) begin
      top_nxt = stk_rdata[STK_W-1:DEG_W];
      cur_nxt = stk_rdata[DEG_W-1:0];
    end
    if (cmd.set_res) begin
      res_nxt = cmd.res_val;
    end
    if (cmd.load_out) begin
      out_reach_nxt = res_r;
    end
  end

  assign sts.in_bad     = (32'(in_node) >= opr_pkg::NODES) ||
                          (32'(in_target) >= opr_pkg::NODES);
  assign sts.cur_done   = cur_r >= deg_eff;
  assign sts.last_frame = depth_r == DEPTH_W'(1);
  assign sts.skip_next  = (32'(adj_rdata) >= opr_pkg::NODES) || visited_r[adj_idx];
  assign sts.own_match  = own_eff == player_r;
  assign sts.goal_hit   = 32'(next_r) == 32'(goal_r);
  assign sts.stack_full = depth_r >= DEPTH_W'(opr_pkg::NODES);

  assign out_reachable = out_reach_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_vld_r <= '0;
      own_vld_r <= '0;
      visited_r <= '0;
      depth_r <= '0;
    end else begin
      deg_vld_r <= deg_vld_nxt;
      own_vld_r <= own_vld_nxt;
      visited_r <= visited_nxt;
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    cur_r <= cur_nxt;
    next_r <= next_nxt;
    goal_r <= goal_nxt;
    player_r <= player_nxt;
    res_r <= res_nxt;
    out_reach_r <= out_reach_nxt;
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned PHASE_WORDS = 170;
  localparam int unsigned RX_HOLD_CYCLES = 400;

  // Tracks the graph as the block sees it and predicts each query answer.
  class reach_scoreboard;
    logic [opr_pkg::NBR_W-1:0] adj_tab[opr_pkg::ADJ_N];
    bit                        adj_known[opr_pkg::ADJ_N];
    int unsigned               deg_tab[opr_pkg::NODES];
    logic [opr_pkg::OWN_W-1:0] own_tab[opr_pkg::NODES];
    bit                        answer_q[$];
    int unsigned               errors;

    function new();
      foreach (adj_known[i]) adj_known[i] = 1'b0;
      foreach (deg_tab[i]) deg_tab[i] = 0;
      foreach (own_tab[i]) own_tab[i] = '0;
      errors = 0;
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("mismatch: %s", what);
    endfunction

    // Number of slots written without a hole, counting up from slot zero.
    function int unsigned known_prefix(int unsigned n);
      int unsigned cnt;
      cnt = 0;
      while (cnt < opr_pkg::MAX_DEGREE && adj_known[n * opr_pkg::MAX_DEGREE + cnt]) cnt++;
      return cnt;
    endfunction

    function bit find_owned_path(int unsigned from, int unsigned goal,
                                 logic [opr_pkg::PLY_W-1:0] who);
      bit          seen[opr_pkg::NODES];
      int unsigned stk[opr_pkg::NODES];
      int unsigned cur[opr_pkg::NODES];
      int unsigned sp;
      int unsigned here;
      int unsigned nxt;
      if (from >= opr_pkg::NODES || goal >= opr_pkg::NODES) return 1'b0;
      foreach (seen[i]) seen[i] = 1'b0;
      seen[from] = 1'b1;
      stk[0] = from;
      cur[0] = 0;
      sp = 1;
      while (sp > 0) begin
        here = stk[sp-1];
        if (cur[sp-1] >= deg_tab[here]) begin
          sp--;
          continue;
        end
        nxt = adj_tab[here * opr_pkg::MAX_DEGREE + cur[sp-1]];
        cur[sp-1]++;
        if (nxt >= opr_pkg::NODES || seen[nxt] || own_tab[nxt] != who) continue;
        if (nxt == goal) return 1'b1;
        seen[nxt] = 1'b1;
        if (sp < opr_pkg::NODES) begin
          stk[sp] = nxt;
          cur[sp] = 0;
          sp++;
        end
      end
      return 1'b0;
    endfunction

    function void note_word(opr_pkg::opcode_t op, logic [31:0] w);
      int unsigned n;
      int unsigned sl;
      int unsigned dg;
      n  = w[5:0];
      sl = w[8:6];
      dg = w[18:15];
      case (op)
        opr_pkg::OP_WR_SLOT: begin
          if (n < opr_pkg::NODES && sl < opr_pkg::MAX_DEGREE) begin
            adj_tab[n * opr_pkg::MAX_DEGREE + sl]   = w[14:9];
            adj_known[n * opr_pkg::MAX_DEGREE + sl] = 1'b1;
          end
        end
        opr_pkg::OP_SET_DEG: begin
          if (n < opr_pkg::NODES)
            deg_tab[n] = (dg > opr_pkg::MAX_DEGREE) ? opr_pkg::MAX_DEGREE : dg;
        end
        opr_pkg::OP_SET_OWN: begin
          if (n < opr_pkg::NODES) own_tab[n] = w[21:19];
        end
        default: begin
          answer_q.insert(answer_q.size(), find_owned_path(n, w[27:22], w[30:28]));
        end
      endcase
    endfunction

    function void check_word(logic [7:0] w);
      bit want;
      if (answer_q.size() == 0) begin
        flag($sformatf("result word %h with no query outstanding", w));
        return;
      end
      want = answer_q.pop_front();
      if (w[0] !== want)
        flag($sformatf("reachable expected %0d, got %b", want, w[0]));
    endfunction

    function int unsigned pending();
      return answer_q.size();
    endfunction

    function void close_out();
      if (answer_q.size() != 0)
        flag($sformatf("%0d query answers never arrived", answer_q.size()));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;

  reach_scoreboard sb = new();
  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned cycles = 0;

  owned_path_reachability_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata);
  end

  // Result side: random back-pressure, plus a long hold-off when one is requested.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  function automatic logic [31:0] pack_word(logic [5:0] n, logic [2:0] sl, logic [5:0] nb,
                                            logic [3:0] dg, logic [2:0] ow, logic [5:0] tg,
                                            logic [2:0] pl);
    return {1'b0, pl, tg, ow, dg, nb, sl, n};
  endfunction

  task automatic send_word(opr_pkg::opcode_t op, logic [31:0] w);
    @(negedge clk);
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
    sb.note_word(op, w);
  endtask

  // Stop offering words until every outstanding query has been answered.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
  endtask

  // Most traffic stays on a small cluster of nodes and two players so that
  // queries find real owned paths; the rest spans the full field ranges.
  function automatic logic [5:0] pick_node();
    return ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(15));
  endfunction

  function automatic logic [2:0] pick_player();
    return ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1));
  endfunction

  task automatic send_random();
    opr_pkg::opcode_t op;
    logic [5:0]       n;
    logic [5:0]       nb;
    logic [5:0]       tg;
    logic [2:0]       sl;
    logic [2:0]       ow;
    logic [2:0]       pl;
    logic [3:0]       dg;
    int unsigned      pick;
    int unsigned      pre;
    pick = $urandom_range(99);
    n  = pick_node();
    nb = pick_node();
    tg = pick_node();
    sl = 3'($urandom_range(7));
    dg = 4'($urandom_range(15));
    ow = pick_player();
    pl = pick_player();
    pre = sb.known_prefix(n);
    if (pick < 30) begin
      op = opr_pkg::OP_WR_SLOT;
      if (pre < opr_pkg::MAX_DEGREE && $urandom_range(1) == 1) sl = 3'(pre);
    end else if (pick < 45) begin
      op = opr_pkg::OP_SET_DEG;
      // A degree never exposes a slot that has not been written.
      dg = (pre == opr_pkg::MAX_DEGREE) ? 4'($urandom_range(15)) : 4'($urandom_range(pre));
    end else if (pick < 57) begin
      op = opr_pkg::OP_SET_OWN;
    end else begin
      op = opr_pkg::OP_QUERY;
    end
    send_word(op, pack_word(n, sl, nb, dg, ow, tg, pl));
  endtask

  initial begin
    int unsigned phase;
    int unsigned k;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = opr_pkg::OP_WR_SLOT;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Empty graph: start has no edges.
    send_word(opr_pkg::OP_QUERY, pack_word(6'd0, 3'd0, 6'd0, 4'd0, 3'd0, 6'd1, 3'd0));
    // Node 63 gets self loops in every slot but the last, which leads to node 0.
    for (k = 0; k < opr_pkg::MAX_DEGREE; k++)
      send_word(opr_pkg::OP_WR_SLOT, pack_word(6'd63, 3'(k), (k == 7) ? 6'd0 : 6'd63,
                                               4'd0, 3'd0, 6'd0, 3'd0));
    send_word(opr_pkg::OP_SET_DEG, pack_word(6'd63, 3'd0, 6'd0, 4'd15, 3'd0, 6'd0, 3'd0));
    send_word(opr_pkg::OP_SET_OWN, pack_word(6'd0, 3'd0, 6'd0, 4'd0, 3'd7, 6'd0, 3'd0));
    // Start is not owned by the player, yet the walk may leave it.
    send_word(opr_pkg::OP_QUERY, pack_word(6'd63, 3'd0, 6'd0, 4'd0, 3'd0, 6'd0, 3'd7));
    send_word(opr_pkg::OP_QUERY, pack_word(6'd63, 3'd0, 6'd0, 4'd0, 3'd0, 6'd0, 3'd6));
    // Start equal to target answers zero even with a self loop.
    send_word(opr_pkg::OP_QUERY, pack_word(6'd63, 3'd0, 6'd0, 4'd0, 3'd0, 6'd63, 3'd0));
    send_word(opr_pkg::OP_WR_SLOT, pack_word(6'd1, 3'd0, 6'd2, 4'd0, 3'd0, 6'd0, 3'd0));
    send_word(opr_pkg::OP_SET_DEG, pack_word(6'd1, 3'd0, 6'd0, 4'd1, 3'd0, 6'd0, 3'd0));
    send_word(opr_pkg::OP_SET_OWN, pack_word(6'd2, 3'd0, 6'd0, 4'd0, 3'd5, 6'd0, 3'd0));
    send_word(opr_pkg::OP_QUERY, pack_word(6'd1, 3'd0, 6'd0, 4'd0, 3'd0, 6'd2, 3'd5));
    // Target owned by someone else.
    send_word(opr_pkg::OP_QUERY, pack_word(6'd1, 3'd0, 6'd0, 4'd0, 3'd0, 6'd2, 3'd3));
    send_word(opr_pkg::OP_SET_DEG, pack_word(6'd1, 3'd0, 6'd0, 4'd0, 3'd0, 6'd0, 3'd0));
    send_word(opr_pkg::OP_QUERY, pack_word(6'd1, 3'd0, 6'd0, 4'd0, 3'd0, 6'd2, 3'd5));
    // Two hops: 63 -> 0 -> 1, both owned by player 7.
    send_word(opr_pkg::OP_WR_SLOT, pack_word(6'd0, 3'd0, 6'd1, 4'd0, 3'd0, 6'd0, 3'd0));
    send_word(opr_pkg::OP_SET_DEG, pack_word(6'd0, 3'd0, 6'd0, 4'd1, 3'd0, 6'd0, 3'd0));
    send_word(opr_pkg::OP_SET_OWN, pack_word(6'd1, 3'd0, 6'd0, 4'd0, 3'd7, 6'd0, 3'd0));
    send_word(opr_pkg::OP_QUERY, pack_word(6'd63, 3'd0, 6'd0, 4'd0, 3'd0, 6'd1, 3'd7));
    drain();

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap_pct = 25;
          recv_gap_pct = 75;
        end
        1: begin
          send_gap_pct = 75;
          recv_gap_pct = 25;
        end
        default: begin
          send_gap_pct = 0;
          recv_gap_pct = 0;
        end
      endcase
      for (k = 0; k < PHASE_WORDS; k++) begin
        send_random();
        // Hold the result side off long enough that the input backs up.
        if (phase == 0 && k == 60) hold_cycles = RX_HOLD_CYCLES;
      end
      drain();
    end

    repeat (100) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
